### rtl/core/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

  // Alphabet select codes for the characters of values 62 and 63.
  localparam logic [1:0] ALPHA_STD = 2'd0;
  localparam logic [1:0] ALPHA_URL = 2'd1;
  localparam logic [1:0] ALPHA_EXT = 2'd2;

  // Register index decode (one register, word aligned).
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_ALPHABET = 1'b0;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // One complete group of three bytes (missing bytes zero) and its pad count.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  npad;
    logic        last;
  } group_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v, input logic [1:0] mode);
    logic [6:0] v7;
    logic [6:0] c;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      c = v7 + 7'd65;              // 'A'..'Z'
    end else if (v < 6'd52) begin
      c = v7 + 7'd71;              // 'a'..'z'
    end else if (v < 6'd62) begin
      c = v7 - 7'd4;               // '0'..'9'
    end else if (v == 6'd62) begin
      unique case (mode)
        ALPHA_URL: c = 7'h2D;      // '-'
        ALPHA_EXT: c = 7'h2E;      // '.'
        default:   c = 7'h2B;      // '+'
      endcase
    end else begin
      unique case (mode)
        ALPHA_URL, ALPHA_EXT: c = 7'h5F;  // '_'
        default:              c = 7'h2F;  // '/'
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/b64e_group.sv
`default_nettype none

// Collect bytes into groups of three; flush a short group on a last byte.
module b64e_group (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 data_valid,
  output logic                data_ready,
  input  wire  [7:0]          data_byte,
  input  wire                 last_byte,
  output logic                grp_valid,
  input  wire                 grp_ready,
  output b64e_pkg::group_t    grp
);

  logic [7:0]        held0;
  logic [7:0]        held1;
  logic [1:0]        held_count;
  logic              accept;
  logic              emit;
  b64e_pkg::group_t  grp_next;

  assign data_ready = !grp_valid || grp_ready;
  assign accept     = data_valid && data_ready;
  assign emit       = held_count[1] || last_byte;

  always_comb begin
    grp_next.last = last_byte;
    if (held_count[1]) begin
      grp_next.word = {held0, held1, data_byte};
      grp_next.npad = 2'd0;
    end else if (held_count[0]) begin
      grp_next.word = {held0, data_byte, 8'd0};
      grp_next.npad = 2'd1;
    end else begin
      grp_next.word = {data_byte, 16'd0};
      grp_next.npad = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      grp_valid  <= 1'b0;
    end else begin
      if (accept && emit) begin
        grp_valid <= 1'b1;
      end else if (grp_ready) begin
        grp_valid <= 1'b0;
      end
      if (accept) begin
        if (emit) begin
          held_count <= 2'd0;
        end else begin
          held_count <= held_count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (emit) begin
        grp <= grp_next;
      end else if (held_count[0]) begin
        held1 <= data_byte;
      end else begin
        held0 <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/b64e_serial.sv
`default_nettype none

// Emit the four characters of a group, one per cycle unless char_ready stalls, through an output register.
module b64e_serial (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [1:0]          alphabet_mode,
  input  wire                 grp_valid,
  output logic                grp_ready,
  input  b64e_pkg::group_t    grp,
  output logic                char_valid,
  input  wire                 char_ready,
  output logic [6:0]          out_char,
  output logic                last_char
);

  b64e_pkg::group_t  cur;
  logic              cur_valid;
  logic [1:0]        idx;
  logic              advance;
  logic              final_char;
  logic [5:0]        sextet;
  logic              pad;
  logic [6:0]        char_next;

  assign advance    = cur_valid && (!char_valid || char_ready);
  assign final_char = (idx == 2'd3);
  assign grp_ready  = !cur_valid || (advance && final_char);

  always_comb begin
    unique case (idx)
      2'd0: sextet = cur.word[23:18];
      2'd1: sextet = cur.word[17:12];
      2'd2: sextet = cur.word[11:6];
      2'd3: sextet = cur.word[5:0];
    endcase
    pad       = (idx == 2'd3 && cur.npad != 2'd0) || (idx == 2'd2 && cur.npad == 2'd2);
    char_next = pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet, alphabet_mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      char_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (advance) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
      if (grp_valid && grp_ready) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (advance) begin
        idx <= idx + 2'd1;
        if (final_char) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char  <= char_next;
      last_char <= cur.last && final_char;
    end
    if (grp_valid && grp_ready) begin
      cur <= grp;
    end
  end

endmodule

`default_nettype wire

### rtl/core/base64_encoder_core.sv
// Channel   Direction  Handshake                Payload
// data      in         data_valid/data_ready    data_byte[7:0], last_byte
// char      out        char_valid/char_ready    out_char[6:0], last_char
// config    in         APB psel/penable/pready  paddr[2:0], pwdata/prdata[31:0]
//
// A byte that closes a group lands in the group register at its accepting
// edge, then passes through the serializer's group register to the output
// register. At one character per cycle while char_ready holds, the serializer
// takes the next group as it emits the fourth character of the current one.
// Reset (rst, synchronous) drops pending bytes, groups and output; standard alphabet.
// A char-side stall holds the output and backs up through both group registers.
`default_nettype none

module base64_encoder_core (
  input  wire         clk,
  input  wire         rst,
  // byte requests
  input  wire         data_valid,
  output logic        data_ready,
  input  wire  [7:0]  data_byte,
  input  wire         last_byte,
  // character requests
  output logic        char_valid,
  input  wire         char_ready,
  output logic [6:0]  out_char,
  output logic        last_char,
  // register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [b64e_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              alphabet_mode_next_en;
  logic [1:0]        alphabet_mode;
  logic              grp_valid;
  logic              grp_ready;
  b64e_pkg::group_t  grp;

  // Register port: zero wait states. Only the alphabet register exists;
  // writes to any other word are dropped and read back as zero.
  assign pready = 1'b1;
  assign alphabet_mode_next_en = psel && penable && pwrite && pready &&
                                 (paddr[2] == b64e_pkg::REG_ALPHABET);

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_mode <= b64e_pkg::ALPHA_STD;
    end else if (alphabet_mode_next_en) begin
      alphabet_mode <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == b64e_pkg::REG_ALPHABET) begin
      prdata[1:0] = alphabet_mode;
    end
  end

  // Byte side: hold up to two bytes, hand complete or flushed groups on.
  b64e_group u_group (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .grp_valid  (grp_valid),
    .grp_ready  (grp_ready),
    .grp        (grp)
  );

  // Character side: map sextets through the selected alphabet, insert pads,
  // mark the fourth character of a group closed by a last byte.
  b64e_serial u_serial (
    .clk           (clk),
    .rst           (rst),
    .alphabet_mode (alphabet_mode),
    .grp_valid     (grp_valid),
    .grp_ready     (grp_ready),
    .grp           (grp),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .out_char      (out_char),
    .last_char     (last_char)
  );

endmodule

`default_nettype wire

### rtl/core/b64e_checker.sv
`default_nettype none

module b64e_checker (
  input wire        clk,
  input wire        rst,
  input wire        char_valid,
  input wire        char_ready,
  input wire [6:0]  out_char,
  input wire        last_char,
  input wire        pready
);

  logic [1:0] pos;
  logic       take;

  assign take = char_valid && char_ready;

  // Track the character position within its group of four.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
    end else if (take) begin
      pos <= pos + 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(out_char) && $stable(last_char))
    else $error("output changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    take && last_char |-> pos == 2'd3)
    else $error("last_char away from the fourth character of a group");

  a_pad_pos: assert property (@(posedge clk) disable iff (rst)
    take && out_char == b64e_pkg::PAD_CHAR |-> pos == 2'd2 || pos == 2'd3)
    else $error("pad character in the first half of a group");

  a_reset: assert property (@(posedge clk)
    rst |=> !char_valid && pready)
    else $error("output valid after reset");

endmodule

bind base64_encoder_core b64e_checker u_b64e_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .out_char   (out_char),
  .last_char  (last_char),
  .pready     (pready)
);

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map: alphabet_mode is register 0 at byte address 0. Address 4
  // decodes to no register, so writes there must leave the alphabet alone.
  localparam logic [b64e_pkg::ADDR_W-1:0] ADDR_ALPHABET = 3'd0;
  localparam logic [b64e_pkg::ADDR_W-1:0] ADDR_SPARE    = 3'd4;

  // Code 3 is not a defined alphabet; the encoder treats it as standard.
  localparam logic [1:0] ALPHA_SPARE = 2'd3;

  localparam int IDLE_PCT     = 17;
  localparam int SETTLE       = 8;       // cycles for a byte to work through
  localparam int LONG_HOLD    = 300;     // receiver hold-off under pressure
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_rec_t;

  // DUT pins; the driven inputs are all known from time zero.
  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              data_valid = 1'b0;
  logic              data_ready;
  logic [7:0]        data_byte  = 8'h00;
  logic              last_byte  = 1'b0;
  logic              char_valid;
  logic              char_ready = 1'b0;
  logic [6:0]        out_char;
  logic              last_char;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [b64e_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata     = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Encoder mirror: pending bytes, their count and the selected alphabet.
  logic [7:0]  mirror_bytes [2];
  logic [1:0]  mirror_count;
  logic [1:0]  mirror_alpha;

  // Characters still owed by the encoder, oldest first.
  char_rec_t   chars_due [$];

  int          errors   = 0;
  int          cycles   = 0;
  logic        idle_on  = 1'b1;   // random idling on both sides
  int unsigned hold_seq = 0;      // bump to request a long receiver hold-off

  base64_encoder_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .out_char   (out_char),
    .last_char  (last_char),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the encoder wedges.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("base64_encoder_core: mismatch");
      $finish;
    end
  end

  // Map a 6-bit value to its ASCII character under the given alphabet.
  function automatic logic [6:0] sextet_ascii(input logic [5:0] v, input logic [1:0] alpha);
    if (v < 6'd26) return 7'(8'h41 + v);
    if (v < 6'd52) return 7'(8'h61 + v - 26);
    if (v < 6'd62) return 7'(8'h30 + v - 52);
    if (v == 6'd62) begin
      if (alpha == b64e_pkg::ALPHA_URL) return 7'h2D;
      if (alpha == b64e_pkg::ALPHA_EXT) return 7'h2E;
      return 7'h2B;
    end
    if (alpha == b64e_pkg::ALPHA_URL || alpha == b64e_pkg::ALPHA_EXT) return 7'h5F;
    return 7'h2F;
  endfunction

  // Advance the mirror by one accepted byte; queue the four characters of
  // any group that the byte closes.
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] word;
    int          nbytes;
    char_rec_t   rec;
    if (mirror_count >= 2'd2) begin
      word   = {mirror_bytes[0], mirror_bytes[1], b};
      nbytes = 3;
    end else if (last) begin
      nbytes = mirror_count + 1;
      word   = (mirror_count == 2'd0) ? {b, 16'h0000} : {mirror_bytes[0], b, 8'h00};
    end else begin
      // hold the byte until its group fills or the message ends
      mirror_bytes[mirror_count[0]] = b;
      mirror_count = mirror_count + 2'd1;
      return;
    end
    mirror_count = 2'd0;
    for (int k = 0; k < 4; k++) begin
      // positions past the last real byte become '=' pads
      rec.ch   = (k > nbytes) ? b64e_pkg::PAD_CHAR
                              : sextet_ascii(word[23 - 6*k -: 6], mirror_alpha);
      rec.last = (k == 3) && last;
      chars_due.push_back(rec);
    end
  endtask

  // Character sink: check every accepted request, then pick next ready.
  always @(posedge clk) begin : char_sink
    char_rec_t   due;
    int          hold_left;
    int unsigned hold_seen;
    if (!rst && char_valid && char_ready) begin
      if (chars_due.size() == 0) begin
        $error("out_char: unexpected character %h (last_char %b)", out_char, last_char);
        errors++;
      end else begin
        due = chars_due.pop_front();
        if (out_char !== due.ch) begin
          $error("out_char: expected %h, got %h", due.ch, out_char);
          errors++;
        end
        if (last_char !== due.last) begin
          $error("last_char: expected %b, got %b", due.last, last_char);
          errors++;
        end
      end
    end
    // pick up a new hold-off request from the test sequence
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      char_ready <= 1'b0;
    end else begin
      char_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one byte request and hold it until the encoder takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      data_valid <= 1'b0;
      do @(posedge clk); while (idle_on && $urandom_range(99) < IDLE_PCT);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    do @(posedge clk); while (!data_ready);
    encode_byte(b, last);
  endtask

  // Send a whole message: random bytes, last mark on the final one.
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // Drop valid, wait until every owed character has come, then let the
  // pipeline settle so nothing is still in flight.
  task automatic drain;
    data_valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, done when pready is high.
  task automatic apb_xfer(input logic wr, input logic [b64e_pkg::ADDR_W-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register while the encoder is idle, mirror it, read the alphabet back.
  task automatic write_reg(input logic [b64e_pkg::ADDR_W-1:0] addr,
                           input logic [31:0] value);
    logic [31:0] rdata;
    drain();
    apb_xfer(1'b1, addr, value, rdata);
    if (addr == ADDR_ALPHABET) mirror_alpha = value[1:0];
    apb_xfer(1'b0, ADDR_ALPHABET, 32'h0, rdata);
    if (rdata[1:0] !== mirror_alpha) begin
      $error("alphabet_mode: expected %0d, got %0d", mirror_alpha, rdata[1:0]);
      errors++;
    end
  endtask

  // Random upper bits show that only the low two bits count.
  task automatic set_alphabet(input logic [1:0] alpha);
    write_reg(ADDR_ALPHABET, {$urandom_range(0, 1) ? 30'($urandom) : 30'h0, alpha});
  endtask

  // Known vectors under the standard alphabet: full group with last on
  // the third byte, one and two byte tails, zero and all-ones bytes.
  task automatic test_directed;
    set_alphabet(b64e_pkg::ALPHA_STD);
    send_byte(8'h4D, 1'b0);    // "Man" -> TWFu
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'h00, 1'b1);    // one byte, two pads
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);    // two bytes, one pad
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);    // group without last, then a tail
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  // Values 62 and 63 under every alphabet code, the unused one included,
  // plus a write to an address with no register behind it.
  task automatic test_alphabets;
    logic [1:0] codes [4] = '{b64e_pkg::ALPHA_STD, b64e_pkg::ALPHA_URL,
                              b64e_pkg::ALPHA_EXT, ALPHA_SPARE};
    foreach (codes[i]) begin
      set_alphabet(codes[i]);
      send_byte(8'hFB, 1'b0);  // 62, 63, 60, pad
      send_byte(8'hFF, 1'b1);
    end
    set_alphabet(b64e_pkg::ALPHA_URL);
    write_reg(ADDR_SPARE, 32'hFFFF_FFFE);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Random messages in phases, an alphabet code chosen per phase, the last at random.
  task automatic test_random_messages(input int items);
    int sent;
    int len;
    logic [1:0] codes [5] = '{b64e_pkg::ALPHA_EXT, b64e_pkg::ALPHA_STD, ALPHA_SPARE,
                              b64e_pkg::ALPHA_URL, b64e_pkg::ALPHA_STD};
    sent = 0;
    for (int p = 0; p < 5; p++) begin
      set_alphabet(p == 4 ? 2'($urandom) : codes[p]);
      while (sent < (p + 1) * items / 5) begin
        // mostly short messages so all tail lengths show up often
        len = ($urandom_range(99) < 10) ? $urandom_range(15, 40) : $urandom_range(1, 9);
        send_message(len);
        sent += len;
        // now and then pause until the encoder has caught up
        if ($urandom_range(99) < 5) drain();
      end
    end
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming, so
  // the encoder fills up and stalls data_ready.
  task automatic test_backpressure;
    set_alphabet(b64e_pkg::ALPHA_STD);
    hold_seq <= hold_seq + 1;
    for (int m = 0; m < 8; m++) send_message($urandom_range(3, 7));
    drain();
  endtask

  // Long run with no idling on either side.
  task automatic test_steady_stream;
    set_alphabet(b64e_pkg::ALPHA_URL);
    idle_on <= 1'b0;
    for (int m = 0; m < 12; m++) send_message($urandom_range(1, 8));
    drain();
    idle_on <= 1'b1;
  endtask

  initial begin
    mirror_bytes[0] = 8'h00;
    mirror_bytes[1] = 8'h00;
    mirror_count    = 2'd0;
    mirror_alpha    = b64e_pkg::ALPHA_STD;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_alphabets();
    test_backpressure();
    test_steady_stream();
    test_random_messages(300);

    drain();
    if (errors == 0) begin
      $display("base64_encoder_core: match");
    end else begin
      $display("base64_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
